// ===== hdl/tlps_pkg.sv =====
// Package for the pedestrian-button traffic light sequencer.
// Holds the phase and state types, register indexes, reset values and the phase step functions.
// No dependencies; imported by traffic_light_pedestrian_sequencer_unit.
`default_nettype none

package tlps_pkg;

	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int WIN_IDX_W = 3;
	localparam int TOG_W = 5;
	localparam int LAMP_W = 6;
	localparam int CODE_W = 3;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOWS_PER_PHASE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_DELAY_TICKS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF_TICKS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_TOGGLES = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RED_HOLD_TICKS = 3'd6;

	// Lamp bit positions, in the order they leave on the output stream.
	localparam int LB_CG = 0;
	localparam int LB_CY = 1;
	localparam int LB_CR = 2;
	localparam int LB_WG = 3;
	localparam int LB_WY = 4;
	localparam int LB_WR = 5;

	// Phase codes as shown on the output stream.
	localparam logic [CODE_W-1:0] CODE_GREEN = 3'd0;
	localparam logic [CODE_W-1:0] CODE_GREEN_WAIT = 3'd1;
	localparam logic [CODE_W-1:0] CODE_YELLOW = 3'd2;
	localparam logic [CODE_W-1:0] CODE_YELLOW_WAIT = 3'd3;
	localparam logic [CODE_W-1:0] CODE_BLINK = 3'd4;
	localparam logic [CODE_W-1:0] CODE_RED = 3'd5;
	localparam logic [CODE_W-1:0] CODE_RED_HOLD = 3'd6;

	typedef enum logic [6:0] {
		PH_GREEN       = 7'b0000001,
		PH_GREEN_WAIT  = 7'b0000010,
		PH_YELLOW      = 7'b0000100,
		PH_YELLOW_WAIT = 7'b0001000,
		PH_BLINK       = 7'b0010000,
		PH_RED         = 7'b0100000,
		PH_RED_HOLD    = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		TR_OPEN,
		TR_REQ,
		TR_END,
		TR_NEXT
	} tick_res_t;

	typedef struct packed {
		logic [CFG_W-1:0]     window_ticks;
		logic [WIN_IDX_W-1:0] windows_per_phase;
		logic [CFG_W-1:0]     short_press_limit;
		logic [CFG_W-1:0]     ack_delay_ticks;
		logic [CFG_W-1:0]     blink_half_ticks;
		logic [TOG_W-1:0]     blink_toggles;
		logic [CFG_W-1:0]     red_hold_ticks;
	} cfg_t;

	typedef struct packed {
		phase_t               phase;
		logic [WIN_IDX_W-1:0] win_idx;
		logic [CNT_W-1:0]     tick;
		logic [CNT_W-1:0]     press;
		logic [CNT_W-1:0]     wait_cnt;
		logic [TOG_W-1:0]     toggles;
		logic                 green_req;
		logic                 yellow_req;
		logic [LAMP_W-1:0]    lamps;
	} st_t;

	localparam cfg_t CFG_RESET = '{
		window_ticks: 16'd1000,
		windows_per_phase: 3'd5,
		short_press_limit: 16'd250,
		ack_delay_ticks: 16'd500,
		blink_half_ticks: 16'd500,
		blink_toggles: 5'd10,
		red_hold_ticks: 16'd5000
	};

	localparam st_t ST_RESET = '{
		phase: PH_GREEN,
		win_idx: '0,
		tick: '0,
		press: '0,
		wait_cnt: '0,
		toggles: '0,
		green_req: 1'b0,
		yellow_req: 1'b0,
		lamps: 6'b000001
	};

	function automatic st_t clear_window(input st_t s);
		st_t r;
		r = s;
		r.win_idx = '0;
		r.tick = '0;
		r.press = '0;
		return r;
	endfunction

	function automatic st_t enter_green(input st_t s);
		st_t r;
		r = s;
		r.lamps = '0;
		r.lamps[LB_CG] = 1'b1;
		r.green_req = 1'b0;
		r.yellow_req = 1'b0;
		r.wait_cnt = '0;
		r.toggles = '0;
		r = clear_window(r);
		r.phase = PH_GREEN;
		return r;
	endfunction

	function automatic st_t yellow_window_toggle(input st_t s);
		st_t r;
		r = s;
		r.lamps[LB_CY] = ~r.lamps[LB_CY];
		if (r.green_req) begin
			r.lamps[LB_WY] = ~r.lamps[LB_WY];
		end
		return r;
	endfunction

	function automatic st_t enter_yellow(input st_t s);
		st_t r;
		r = s;
		r.lamps[LB_CG] = 1'b0;
		r = clear_window(r);
		r.phase = PH_YELLOW;
		r = yellow_window_toggle(r);
		return r;
	endfunction

	function automatic st_t leave_yellow(input st_t s);
		st_t r;
		r = s;
		r.lamps[LB_CY] = 1'b0;
		if (r.green_req || r.yellow_req) begin
			r.lamps[LB_WY] = 1'b0;
			r.lamps[LB_WR] = 1'b0;
			r.lamps[LB_WG] = 1'b1;
		end
		r.lamps[LB_CR] = 1'b1;
		r = clear_window(r);
		r.phase = PH_RED;
		return r;
	endfunction

	// A blink interval of zero behaves as one tick.
	function automatic logic [CNT_W-1:0] blink_wait(input cfg_t c);
		logic [CNT_W-1:0] w;
		w = CNT_W'(c.blink_half_ticks);
		if (w == '0) begin
			w = CNT_W'(1);
		end
		return w;
	endfunction

	function automatic st_t start_blink(input st_t s, input cfg_t c);
		st_t r;
		r = s;
		if (c.blink_toggles == '0) begin
			r = leave_yellow(r);
		end else begin
			r.lamps[LB_CY] = ~r.lamps[LB_CY];
			r.lamps[LB_WY] = ~r.lamps[LB_WY];
			r.toggles = TOG_W'(1);
			r.wait_cnt = blink_wait(c);
			r.phase = PH_BLINK;
		end
		return r;
	endfunction

	// One tick of a counting window: counts the press and closes the window at its end.
	function automatic tick_res_t count_tick(input st_t s, input logic pressed, input cfg_t c,
		output st_t r);
		logic [CNT_W:0]       t;
		logic                 req;
		logic [WIN_IDX_W:0]   idx_inc;
		tick_res_t            res;
		r = s;
		if (pressed && (r.press != CNT_MAX)) begin
			r.press = r.press + CNT_W'(1);
		end
		t = {1'b0, r.tick} + (CNT_W+1)'(1);
		idx_inc = {1'b0, r.win_idx} + (WIN_IDX_W+1)'(1);
		req = (r.press != '0) && ({1'b0, r.press} < (CNT_W+1)'(c.short_press_limit));
		if ((t < (CNT_W+1)'(c.window_ticks)) && (t < {1'b0, CNT_MAX})) begin
			r.tick = t[CNT_W-1:0];
			res = TR_OPEN;
		end else begin
			r.tick = '0;
			r.press = '0;
			if (req) begin
				res = TR_REQ;
			end else if (idx_inc >= {1'b0, c.windows_per_phase}) begin
				res = TR_END;
			end else begin
				r.win_idx = idx_inc[WIN_IDX_W-1:0];
				res = TR_NEXT;
			end
		end
		return res;
	endfunction

	// Counts down a wait; true on the tick that ends it.
	function automatic logic wait_step(input st_t s, output st_t r);
		logic done;
		r = s;
		if (r.wait_cnt > CNT_W'(1)) begin
			r.wait_cnt = r.wait_cnt - CNT_W'(1);
			done = 1'b0;
		end else begin
			r.wait_cnt = '0;
			done = 1'b1;
		end
		return done;
	endfunction

	function automatic logic [CODE_W-1:0] phase_code(input phase_t p);
		logic [CODE_W-1:0] code;
		unique case (p)
			PH_GREEN:       code = CODE_GREEN;
			PH_GREEN_WAIT:  code = CODE_GREEN_WAIT;
			PH_YELLOW:      code = CODE_YELLOW;
			PH_YELLOW_WAIT: code = CODE_YELLOW_WAIT;
			PH_BLINK:       code = CODE_BLINK;
			PH_RED:         code = CODE_RED;
			PH_RED_HOLD:    code = CODE_RED_HOLD;
			default:        code = CODE_GREEN;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/traffic_light_pedestrian_sequencer_unit.sv =====
// Top level of the pedestrian-button traffic light sequencer.
// Holds the configuration registers, the phase state, the next-state logic and the result register.
// Depends on tlps_pkg.
//
// Usage: every item on the slave stream is one millisecond tick; bit 0 of s_tdata is the
// button sample for that tick. For each accepted item exactly one result item leaves on
// the master stream, carrying the six lamp levels and the phase code after that tick.
// The configuration port writes one of seven registers per cycle (index on cfg_addr,
// value on cfg_wdata, strobe cfg_wr_en); writes take effect for the next item and should
// only be made while no result is outstanding.
//
// Timing and throughput: the whole phase step is worked out in the cycle an item is
// accepted, between the phase state registers and the result register, so the result is
// presented on m_tdata in the cycle after acceptance. One item is taken every clock cycle
// while results are being drained, since the phase update is combinational.
//
// Stalling: the result register is the only buffer. While it holds a result that the
// receiver has not taken, s_tready is low; once m_tready is seen high the next item is
// taken in the same cycle the held result leaves.
//
// Reset: arst_n clears the output valid flag at once, loads the configuration and phase
// state registers with their reset values and starts in the car green phase with only car green lit.
`default_nettype none

module traffic_light_pedestrian_sequencer_unit import tlps_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Configuration write port.
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	// Tick stream in.
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,   // [0] button_down, [7:1] zero
	// Lamp stream out.
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [15:0]               m_tdata    // [0] car_green, [1] car_yellow,
	                                             // [2] car_red, [3] walk_green,
	                                             // [4] walk_yellow, [5] walk_red,
	                                             // [8:6] phase_code, [15:9] zero
);

	cfg_t cfg_q;
	st_t  st_q;
	st_t  st_nx;

	logic                  m_tvalid_q;
	logic [LAMP_W-1:0]     lamps_q;
	logic [CODE_W-1:0]     code_q;
	logic                  in_accept;
	logic                  button;

	// The result register can take a new result when empty or when its content leaves now.
	assign s_tready  = !m_tvalid_q || m_tready;
	assign in_accept = s_tvalid && s_tready;
	assign button    = s_tdata[0];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_WINDOW_TICKS:      cfg_q.window_ticks <= cfg_wdata;
				REG_WINDOWS_PER_PHASE: cfg_q.windows_per_phase <= cfg_wdata[WIN_IDX_W-1:0];
				REG_SHORT_PRESS_LIMIT: cfg_q.short_press_limit <= cfg_wdata;
				REG_ACK_DELAY_TICKS:   cfg_q.ack_delay_ticks <= cfg_wdata;
				REG_BLINK_HALF_TICKS:  cfg_q.blink_half_ticks <= cfg_wdata;
				REG_BLINK_TOGGLES:     cfg_q.blink_toggles <= cfg_wdata[TOG_W-1:0];
				REG_RED_HOLD_TICKS:    cfg_q.red_hold_ticks <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Phase step for one tick. Only one phase's counting or waiting runs per tick, so the
	// path is that phase's counter updates and compares and the lamp update.
	always_comb begin
		st_t       tmp;
		tick_res_t res;
		logic      done;
		st_nx = st_q;
		tmp   = st_q;
		res   = TR_OPEN;
		done  = 1'b0;
		unique case (st_q.phase)
			PH_GREEN: begin
				res = count_tick(st_q, button, cfg_q, tmp);
				st_nx = tmp;
				if (res == TR_REQ) begin
					st_nx.lamps[LB_WR] = 1'b1;
					st_nx.green_req = 1'b1;
					if (cfg_q.ack_delay_ticks != '0) begin
						st_nx.wait_cnt = CNT_W'(cfg_q.ack_delay_ticks);
						st_nx.phase = PH_GREEN_WAIT;
					end else begin
						st_nx = enter_yellow(st_nx);
					end
				end else if (res == TR_END) begin
					st_nx = enter_yellow(st_nx);
				end
			end
			PH_GREEN_WAIT: begin
				done = wait_step(st_q, tmp);
				st_nx = done ? enter_yellow(tmp) : tmp;
			end
			PH_YELLOW: begin
				res = count_tick(st_q, button, cfg_q, tmp);
				st_nx = tmp;
				if (res == TR_REQ) begin
					st_nx.lamps[LB_WR] = 1'b1;
					st_nx.yellow_req = 1'b1;
					if (cfg_q.ack_delay_ticks != '0) begin
						st_nx.wait_cnt = CNT_W'(cfg_q.ack_delay_ticks);
						st_nx.phase = PH_YELLOW_WAIT;
					end else begin
						st_nx = start_blink(st_nx, cfg_q);
					end
				end else if (res == TR_END) begin
					st_nx = leave_yellow(st_nx);
				end else if (res == TR_NEXT) begin
					// Each new yellow window flips car yellow, and walk yellow too after a green request.
					st_nx = yellow_window_toggle(st_nx);
				end
			end
			PH_YELLOW_WAIT: begin
				done = wait_step(st_q, tmp);
				st_nx = done ? start_blink(tmp, cfg_q) : tmp;
			end
			PH_BLINK: begin
				done = wait_step(st_q, tmp);
				st_nx = tmp;
				if (done) begin
					if (st_q.toggles < cfg_q.blink_toggles) begin
						st_nx.lamps[LB_CY] = ~st_nx.lamps[LB_CY];
						st_nx.lamps[LB_WY] = ~st_nx.lamps[LB_WY];
						st_nx.toggles = st_q.toggles + TOG_W'(1);
						st_nx.wait_cnt = blink_wait(cfg_q);
					end else begin
						st_nx = leave_yellow(st_nx);
					end
				end
			end
			PH_RED: begin
				res = count_tick(st_q, button, cfg_q, tmp);
				st_nx = tmp;
				if (res == TR_REQ) begin
					st_nx.lamps[LB_WG] = 1'b1;
					if (cfg_q.red_hold_ticks != '0) begin
						st_nx.wait_cnt = CNT_W'(cfg_q.red_hold_ticks);
						st_nx.phase = PH_RED_HOLD;
					end else begin
						st_nx = enter_green(st_nx);
					end
				end else if (res == TR_END) begin
					st_nx = enter_green(st_nx);
				end
			end
			PH_RED_HOLD: begin
				done = wait_step(st_q, tmp);
				st_nx = done ? enter_green(tmp) : tmp;
			end
			default: begin
				st_nx = enter_green(st_q);
			end
		endcase
	end

	// Phase state advances once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (in_accept) begin
			st_q <= st_nx;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (in_accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			lamps_q <= st_nx.lamps;
			code_q  <= phase_code(st_nx.phase);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, code_q, lamps_q};

	// Walk green and walk red are never lit together.
	a_walk_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_q.lamps[LB_WG] && st_q.lamps[LB_WR]))
		else $error("walk green and walk red lit together");

	// Car green is lit exactly in the two green phases.
	a_car_green_phase: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.lamps[LB_CG] == ((st_q.phase == PH_GREEN) || (st_q.phase == PH_GREEN_WAIT)))
		else $error("car green lamp out of step with phase");

	// The wait counter only runs in the wait, blink and hold phases.
	a_wait_idle: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q.phase == PH_GREEN) || (st_q.phase == PH_YELLOW) || (st_q.phase == PH_RED))
		|-> (st_q.wait_cnt == '0))
		else $error("wait counter running in a counting phase");

	// A held result that is not taken blocks the input side.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input accepted while result register is full");

endmodule

`default_nettype wire

// ===== dv/tb_traffic_light_pedestrian_sequencer_unit.sv =====
// Self-checking testbench for traffic_light_pedestrian_sequencer_unit.
// Drives button ticks, predicts the lamp levels and phase code of every tick, and compares.
// Depends on tlps_pkg and the unit itself; needs no files or arguments.
module tb_traffic_light_pedestrian_sequencer_unit;
	import tlps_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RUN_LIMIT = 1_000_000;
	localparam int RANDOM_TICKS = 1300;
	localparam int QUIET_AFTER = 1100;
	localparam int LONG_HOLD_AT = 150;
	localparam int LONG_HOLD_CYCLES = 64;
	localparam int LONG_HOLD_BACKLOG = 16;

	// Predicted state of the sequencer; the phase is held as its output code.
	typedef struct packed {
		logic [CODE_W-1:0]    code;
		logic [WIN_IDX_W-1:0] window;
		logic [CNT_W-1:0]     tick;
		logic [CNT_W-1:0]     presses;
		logic [CNT_W-1:0]     wait_left;
		logic [TOG_W-1:0]     toggles;
		logic                 green_req;
		logic                 yellow_req;
		logic [LAMP_W-1:0]    lamps;
	} lights_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;

	// The predictor's copy of the registers and of the phase state.
	cfg_t cfg_now;
	lights_t lights;

	// Button samples waiting to be offered, and lamp words awaited at the output.
	bit tick_queue[$];
	logic [LAMP_W+CODE_W-1:0] expected_lamps[$];

	string lamp_name[LAMP_W] = '{"car_green", "car_yellow", "car_red",
		"walk_green", "walk_yellow", "walk_red"};

	int ticks_queued = 0;
	int results_checked = 0;
	int faults = 0;
	int cycle_count = 0;
	bit idle_on = 1'b1;
	int gap_left = 0;
	int stall_left = 0;
	int long_hold_left = 0;
	bit long_hold_done = 1'b0;
	logic [LAMP_W+CODE_W-1:0] seen;
	logic [LAMP_W+CODE_W-1:0] want;
	int k;
	int press_odds;
	int phase_ticks;
	int wt, wpp, lim, ack, bh, tog, hold;

	traffic_light_pedestrian_sequencer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // [0] button_down, [7:1] zero
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)     // [5:0] lamps from car_green up, [8:6] phase_code
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------------------------
	// Predictor. Each function works on the module's copy of the state and registers.
	// ---------------------------------------------------------------------------------

	// A new cycle: car green alone is lit and every counter and request flag clears.
	function automatic void restart_cycle();
		lights = '0;
		lights.lamps[LB_CG] = 1'b1;
		lights.code = CODE_GREEN;
	endfunction

	// Yellow lamps flip at the opening of each yellow window; the walk yellow lamp only
	// joins in once a pedestrian asked during green.
	function automatic void flip_yellow_lamps();
		lights.lamps[LB_CY] = ~lights.lamps[LB_CY];
		if (lights.green_req) begin
			lights.lamps[LB_WY] = ~lights.lamps[LB_WY];
		end
	endfunction

	function automatic void to_yellow();
		lights.lamps[LB_CG] = 1'b0;
		lights.window = '0;
		lights.tick = '0;
		lights.presses = '0;
		lights.code = CODE_YELLOW;
		flip_yellow_lamps();
	endfunction

	// Car red comes on; if anyone asked in green or yellow, pedestrians get walk green.
	function automatic void to_red();
		lights.lamps[LB_CY] = 1'b0;
		if (lights.green_req || lights.yellow_req) begin
			lights.lamps[LB_WY] = 1'b0;
			lights.lamps[LB_WR] = 1'b0;
			lights.lamps[LB_WG] = 1'b1;
		end
		lights.lamps[LB_CR] = 1'b1;
		lights.window = '0;
		lights.tick = '0;
		lights.presses = '0;
		lights.code = CODE_RED;
	endfunction

	// A zero blink interval still waits one tick per toggle.
	function automatic logic [CNT_W-1:0] blink_interval();
		return (cfg_now.blink_half_ticks == '0) ? CNT_W'(1) : cfg_now.blink_half_ticks;
	endfunction

	function automatic void begin_blink();
		if (cfg_now.blink_toggles == '0) begin
			to_red();
		end else begin
			lights.lamps[LB_CY] = ~lights.lamps[LB_CY];
			lights.lamps[LB_WY] = ~lights.lamps[LB_WY];
			lights.toggles = TOG_W'(1);
			lights.wait_left = blink_interval();
			lights.code = CODE_BLINK;
		end
	endfunction

	// Counts one sample into the open window. A closing window with a press count that
	// is nonzero and under the short-press limit is a request; otherwise the phase ends
	// once its window budget is spent. The press count sticks at its top value, and the
	// window also closes when its tick counter would reach the top.
	function automatic tick_res_t count_window_tick(input logic pressed);
		logic [CNT_W:0] nxt;
		logic asked;
		if (pressed && lights.presses != CNT_MAX) begin
			lights.presses = lights.presses + 1'b1;
		end
		nxt = {1'b0, lights.tick} + 1'b1;
		if (nxt < {1'b0, cfg_now.window_ticks} && nxt < {1'b0, CNT_MAX}) begin
			lights.tick = nxt[CNT_W-1:0];
			return TR_OPEN;
		end
		asked = lights.presses != '0 && lights.presses < cfg_now.short_press_limit;
		lights.tick = '0;
		lights.presses = '0;
		if (asked) begin
			return TR_REQ;
		end
		if ({1'b0, lights.window} + 1'b1 >= {1'b0, cfg_now.windows_per_phase}) begin
			return TR_END;
		end
		lights.window = lights.window + 1'b1;
		return TR_NEXT;
	endfunction

	// One tick of a wait; true on the tick that finishes it (at once for a zero count).
	function automatic logic wait_over();
		if (lights.wait_left > CNT_W'(1)) begin
			lights.wait_left = lights.wait_left - 1'b1;
			return 1'b0;
		end
		lights.wait_left = '0;
		return 1'b1;
	endfunction

	function automatic void advance_lights(input logic pressed);
		tick_res_t ev;
		case (lights.code)
			CODE_GREEN: begin
				ev = count_window_tick(pressed);
				if (ev == TR_REQ) begin
					lights.lamps[LB_WR] = 1'b1;
					lights.green_req = 1'b1;
					if (cfg_now.ack_delay_ticks != '0) begin
						lights.wait_left = cfg_now.ack_delay_ticks;
						lights.code = CODE_GREEN_WAIT;
					end else begin
						to_yellow();
					end
				end else if (ev == TR_END) begin
					to_yellow();
				end
			end
			CODE_GREEN_WAIT: begin
				if (wait_over()) begin
					to_yellow();
				end
			end
			CODE_YELLOW: begin
				ev = count_window_tick(pressed);
				if (ev == TR_REQ) begin
					lights.lamps[LB_WR] = 1'b1;
					lights.yellow_req = 1'b1;
					if (cfg_now.ack_delay_ticks != '0) begin
						lights.wait_left = cfg_now.ack_delay_ticks;
						lights.code = CODE_YELLOW_WAIT;
					end else begin
						begin_blink();
					end
				end else if (ev == TR_END) begin
					to_red();
				end else if (ev == TR_NEXT) begin
					flip_yellow_lamps();
				end
			end
			CODE_YELLOW_WAIT: begin
				if (wait_over()) begin
					begin_blink();
				end
			end
			CODE_BLINK: begin
				if (wait_over()) begin
					if (lights.toggles < cfg_now.blink_toggles) begin
						lights.lamps[LB_CY] = ~lights.lamps[LB_CY];
						lights.lamps[LB_WY] = ~lights.lamps[LB_WY];
						lights.toggles = lights.toggles + 1'b1;
						lights.wait_left = blink_interval();
					end else begin
						to_red();
					end
				end
			end
			CODE_RED: begin
				ev = count_window_tick(pressed);
				if (ev == TR_REQ) begin
					lights.lamps[LB_WG] = 1'b1;
					if (cfg_now.red_hold_ticks != '0) begin
						lights.wait_left = cfg_now.red_hold_ticks;
						lights.code = CODE_RED_HOLD;
					end else begin
						restart_cycle();
					end
				end else if (ev == TR_END) begin
					restart_cycle();
				end
			end
			CODE_RED_HOLD: begin
				if (wait_over()) begin
					restart_cycle();
				end
			end
			default: begin
				restart_cycle();
			end
		endcase
	endfunction

	// ---------------------------------------------------------------------------------
	// Sender: offers queued button samples, with short random gaps after some items
	// while idling is enabled. A new item is only loaded once the last one was taken.
	// ---------------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!s_tvalid || s_tready) begin
			if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (tick_queue.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= {7'b0, tick_queue.pop_front()};
				if (idle_on && $urandom_range(0, 5) == 0) begin
					gap_left <= $urandom_range(1, 4);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Receiver: random stalls plus a single long hold-off once enough results have passed
	// and the sender still has a backlog of items. During that hold the result register
	// stays full, so the unit must drop s_tready while the sender keeps offering.
	// ---------------------------------------------------------------------------------
	always @(posedge clk) begin
		if (long_hold_left != 0) begin
			m_tready <= 1'b0;
			long_hold_left <= long_hold_left - 1;
		end else if (!long_hold_done && results_checked >= LONG_HOLD_AT &&
			tick_queue.size() > LONG_HOLD_BACKLOG) begin
			m_tready <= 1'b0;
			long_hold_left <= LONG_HOLD_CYCLES;
			long_hold_done <= 1'b1;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------------------------
	// Monitor: the result leaving at this edge belongs to an older item than the one
	// entering, so it is checked before the new prediction is queued.
	// ---------------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen = m_tdata[LAMP_W+CODE_W-1:0];
				if (expected_lamps.size() == 0) begin
					$display("%0t: result %h arrived with no item outstanding", $time, seen);
					faults++;
				end else begin
					want = expected_lamps.pop_front();
					for (k = 0; k < LAMP_W; k++) begin
						if (seen[k] !== want[k]) begin
							$display("%0t: %s expected %b actual %b", $time, lamp_name[k],
								want[k], seen[k]);
							faults++;
						end
					end
					if (seen[LAMP_W +: CODE_W] !== want[LAMP_W +: CODE_W]) begin
						$display("%0t: phase_code expected %0d actual %0d", $time,
							want[LAMP_W +: CODE_W], seen[LAMP_W +: CODE_W]);
						faults++;
					end
				end
				results_checked <= results_checked + 1;
			end
			if (s_tvalid && s_tready) begin
				advance_lights(s_tdata[0]);
				expected_lamps.push_back({lights.code, lights.lamps});
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("traffic_light_pedestrian_sequencer_unit verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stimulus sequencing.
	// ---------------------------------------------------------------------------------

	// One register write; the predictor's copy takes the new value when the write is driven, ahead of the unit.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		logic [CFG_W-1:0] v;
		v = CFG_W'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		case (idx)
			REG_WINDOW_TICKS: cfg_now.window_ticks = v;
			REG_WINDOWS_PER_PHASE: cfg_now.windows_per_phase = v[WIN_IDX_W-1:0];
			REG_SHORT_PRESS_LIMIT: cfg_now.short_press_limit = v;
			REG_ACK_DELAY_TICKS: cfg_now.ack_delay_ticks = v;
			REG_BLINK_HALF_TICKS: cfg_now.blink_half_ticks = v;
			REG_BLINK_TOGGLES: cfg_now.blink_toggles = v[TOG_W-1:0];
			REG_RED_HOLD_TICKS: cfg_now.red_hold_ticks = v;
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Writes all seven registers and then steps off the rising edge so that queue
	// updates never share a time step with the sender.
	task automatic apply_settings(input int win_ticks, input int win_count, input int limit,
		input int ack_delay, input int blink_half, input int blink_count, input int red_hold);
		write_reg(REG_WINDOW_TICKS, win_ticks);
		write_reg(REG_WINDOWS_PER_PHASE, win_count);
		write_reg(REG_SHORT_PRESS_LIMIT, limit);
		write_reg(REG_ACK_DELAY_TICKS, ack_delay);
		write_reg(REG_BLINK_HALF_TICKS, blink_half);
		write_reg(REG_BLINK_TOGGLES, blink_count);
		write_reg(REG_RED_HOLD_TICKS, red_hold);
		@(negedge clk);
	endtask

	task automatic queue_tick(input bit pressed);
		tick_queue.push_back(pressed);
		ticks_queued++;
	endtask

	// Waits until every item has been taken and every result checked. The unit holds no
	// work beyond its result register, so the spare cycles at the end make it safe to
	// reconfigure.
	task automatic drain();
		while (tick_queue.size() != 0 || s_tvalid || expected_lamps.size() != 0) begin
			@(negedge clk);
		end
		repeat (3) @(negedge clk);
	endtask

	initial begin
		cfg_now = CFG_RESET;
		restart_cycle();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Out of reset only car green is lit; a few quiet ticks under the reset settings.
		repeat (3) queue_tick(1'b0);
		drain();

		// One-tick windows with a limit of two: a single press is a request in every
		// phase. No acknowledge delay, no red hold, one blink toggle at a zero interval.
		apply_settings(1, 1, 2, 0, 0, 1, 0);
		queue_tick(1'b1);
		queue_tick(1'b1);
		queue_tick(1'b0);
		queue_tick(1'b1);
		queue_tick(1'b0);
		queue_tick(1'b0);
		queue_tick(1'b0);
		queue_tick(1'b0);
		queue_tick(1'b1);
		drain();

		// Every register at zero: windows act as one tick, no request is ever made, and
		// the waits, hold and blink are all skipped.
		apply_settings(0, 0, 0, 0, 0, 0, 0);
		queue_tick(1'b1);
		queue_tick(1'b1);
		queue_tick(1'b1);
		queue_tick(1'b0);
		drain();

		// Multi-window phases with the largest press limit and short waits.
		apply_settings(3, 2, 65535, 2, 2, 2, 3);
		queue_tick(1'b1);
		queue_tick(1'b0);
		queue_tick(1'b0);
		queue_tick(1'b1);
		queue_tick(1'b1);
		queue_tick(1'b0);
		queue_tick(1'b1);
		queue_tick(1'b0);
		drain();

		// Random part: short windows and small limits keep requests frequent, so every
		// phase, wait and blink is visited many times. Press density changes per batch.
		while (ticks_queued < RANDOM_TICKS) begin
			if (ticks_queued > QUIET_AFTER) begin
				idle_on = 1'b0;
			end
			wt = ($urandom_range(0, 15) == 0) ? 0 :
				($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			wpp = $urandom_range(0, 7);
			case ($urandom_range(0, 7))
				0: lim = 0;
				1: lim = 65535;
				default: lim = $urandom_range(1, 6);
			endcase
			ack = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			bh = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
			case ($urandom_range(0, 7))
				0: tog = 0;
				1: tog = 31;
				default: tog = $urandom_range(1, 5);
			endcase
			hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			apply_settings(wt, wpp, lim, ack, bh, tog, hold);
			case ($urandom_range(0, 4))
				0: press_odds = 0;
				1: press_odds = 1;
				2: press_odds = 4;
				3: press_odds = 7;
				default: press_odds = 8;
			endcase
			phase_ticks = $urandom_range(60, 140);
			repeat (phase_ticks) queue_tick($urandom_range(0, 7) < press_odds);
			drain();
		end

		// Bring the sequencer round to a fresh car green phase with single-tick phases,
		// then run one long window with the button held throughout: the press count
		// reaches the window length, which is not below the press limit, so the phase
		// ends normally. The waits go to their largest values.
		idle_on = 1'b0;
		apply_settings(0, 0, 0, 0, 0, 0, 0);
		while (lights.code != CODE_GREEN) begin
			queue_tick(1'b0);
			drain();
		end
		apply_settings(200, 1, 150, 65535, 65535, 31, 65535);
		repeat (200) queue_tick(1'b1);
		repeat (3) queue_tick(1'b0);
		drain();

		if (expected_lamps.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_lamps.size());
			faults++;
		end
		if (faults == 0) begin
			$display("traffic_light_pedestrian_sequencer_unit verification clean");
		end else begin
			$display("traffic_light_pedestrian_sequencer_unit verification failed");
		end
		$finish;
	end

endmodule
